@@ rtl/core/fa_pkg.sv @@
package fa_pkg;

    localparam int FRAC_BITS = 8;
    localparam int DATA_W    = 32;
    localparam int QUO_W     = DATA_W + FRAC_BITS;
    localparam int PROD_W    = 2 * DATA_W;
    localparam int EXT_W     = QUO_W + 1;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef enum logic [3:0] {
        OP_ADD      = 4'd0,
        OP_SUB      = 4'd1,
        OP_MUL      = 4'd2,
        OP_DIV      = 4'd3,
        OP_GT       = 4'd4,
        OP_GE       = 4'd5,
        OP_LT       = 4'd6,
        OP_LE       = 4'd7,
        OP_EQ       = 4'd8,
        OP_NE       = 4'd9,
        OP_MIN      = 4'd10,
        OP_MAX      = 4'd11,
        OP_INC      = 4'd12,
        OP_DEC      = 4'd13,
        OP_FROM_INT = 4'd14,
        OP_TO_INT   = 4'd15
    } t_op;

    typedef enum logic [1:0] {
        KIND_DONE = 2'd0,
        KIND_MUL  = 2'd1,
        KIND_DIV  = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [DATA_W-1:0]  res;
        logic               cmp;
        logic               dbz;
        logic               ovf;
        logic               neg;
        logic [DATA_W-1:0]  mag_a;
        logic [DATA_W-1:0]  mag_b;
    } t_item;

    typedef struct packed {
        t_item              item;
        logic [PROD_W-1:0]  prod;
        logic [DATA_W:0]    rem;
        logic [QUO_W-1:0]   quo;
        logic [QUO_W-1:0]   dvd;
    } t_work;

    typedef struct packed {
        logic [DATA_W-1:0] res;
        logic              cmp;
        logic              dbz;
        logic              ovf;
    } t_result;

endpackage

@@ rtl/core/fa_front.sv @@
module fa_front (
    input  fa_pkg::t_op                  i_op,
    input  logic [fa_pkg::DATA_W-1:0]    i_a,
    input  logic [fa_pkg::DATA_W-1:0]    i_b,
    output fa_pkg::t_item                o_item
);
    import fa_pkg::*;

    localparam logic signed [EXT_W-1:0] MAX_V = EXT_W'((64'sd1 <<< (DATA_W-1)) - 64'sd1);
    localparam logic signed [EXT_W-1:0] MIN_V = -EXT_W'(64'sd1 <<< (DATA_W-1));

    logic signed [EXT_W-1:0] ea;
    logic signed [EXT_W-1:0] eb;
    logic signed [EXT_W-1:0] v;
    logic                    sat_needed;

    assign ea = EXT_W'($signed(i_a));
    assign eb = EXT_W'($signed(i_b));

    always_comb begin
        o_item       = '0;
        o_item.kind  = KIND_DONE;
        o_item.neg   = i_a[DATA_W-1] ^ i_b[DATA_W-1];
        o_item.mag_a = i_a[DATA_W-1] ? (~i_a + 1'b1) : i_a;
        o_item.mag_b = i_b[DATA_W-1] ? (~i_b + 1'b1) : i_b;
        v            = '0;
        sat_needed   = 1'b0;
        case (i_op)
            OP_ADD: begin
                v = ea + eb;
                sat_needed = 1'b1;
            end
            OP_SUB: begin
                v = ea - eb;
                sat_needed = 1'b1;
            end
            OP_MUL: o_item.kind = KIND_MUL;
            OP_DIV: begin
                if (i_b == '0) begin
                    o_item.dbz = 1'b1;
                end else begin
                    o_item.kind = KIND_DIV;
                end
            end
            OP_GT: o_item.cmp = $signed(i_a) > $signed(i_b);
            OP_GE: o_item.cmp = $signed(i_a) >= $signed(i_b);
            OP_LT: o_item.cmp = $signed(i_a) < $signed(i_b);
            OP_LE: o_item.cmp = $signed(i_a) <= $signed(i_b);
            OP_EQ: o_item.cmp = i_a == i_b;
            OP_NE: o_item.cmp = i_a != i_b;
            OP_MIN: o_item.res = ($signed(i_a) > $signed(i_b)) ? i_b : i_a;
            OP_MAX: o_item.res = ($signed(i_a) > $signed(i_b)) ? i_a : i_b;
            OP_INC: begin
                v = ea + EXT_W'(1);
                sat_needed = 1'b1;
            end
            OP_DEC: begin
                v = ea - EXT_W'(1);
                sat_needed = 1'b1;
            end
            OP_FROM_INT: begin
                v = ea <<< FRAC_BITS;
                sat_needed = 1'b1;
            end
            OP_TO_INT: o_item.res = DATA_W'($signed(i_a) >>> FRAC_BITS);
            default: o_item.res = '0;
        endcase
        if (sat_needed) begin
            if (v > MAX_V) begin
                o_item.res = MAX_V[DATA_W-1:0];
                o_item.ovf = 1'b1;
            end else if (v < MIN_V) begin
                o_item.res = MIN_V[DATA_W-1:0];
                o_item.ovf = 1'b1;
            end else begin
                o_item.res = v[DATA_W-1:0];
            end
        end
    end

endmodule

@@ rtl/core/fa_queue.sv @@
module fa_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  fa_pkg::t_item i_item,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output fa_pkg::t_item o_item
);
    import fa_pkg::*;

    t_item                 r_mem [0:QUEUE_DEPTH-1];
    logic [QUEUE_AW-1:0]   r_wp;
    logic [QUEUE_AW-1:0]   r_rp;
    logic [QUEUE_AW:0]     r_cnt;
    logic                  do_push;
    logic                  do_pop;

    assign o_full  = r_cnt == (QUEUE_AW+1)'(QUEUE_DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_item  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_item;
        end
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (QUEUE_AW+1)'(do_push) - (QUEUE_AW+1)'(do_pop);
        end
    end

endmodule

@@ rtl/core/fa_back.sv @@
module fa_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  fa_pkg::t_item   i_item,
    output logic            o_pop,
    output logic            o_valid,
    output fa_pkg::t_result o_result,
    input  logic            i_ready
);
    import fa_pkg::*;

    localparam logic [PROD_W-1:0] HALF     = PROD_W'(1) << (FRAC_BITS - 1);
    localparam logic [PROD_W-1:0] POS_LIM  = (PROD_W'(1) << (DATA_W - 1)) - PROD_W'(1);
    localparam logic [PROD_W-1:0] NEG_LIM  = PROD_W'(1) << (DATA_W - 1);

    t_work           r_w [0:QUO_W];
    logic            r_v [0:QUO_W];
    t_work           n_w [1:QUO_W];
    t_result         r_out;
    logic            r_out_v;
    t_result         n_out;
    logic            en;
    logic [PROD_W-1:0] q;
    logic [DATA_W:0]   trial;
    t_work             last;

    assign en       = !r_out_v || i_ready;
    assign o_pop    = en;
    assign o_valid  = r_out_v;
    assign o_result = r_out;

    always_comb begin
        for (int k = 1; k <= QUO_W; k++) begin
            n_w[k] = r_w[k-1];
            trial  = {r_w[k-1].rem[DATA_W-1:0], r_w[k-1].dvd[QUO_W-1]};
            n_w[k].dvd = {r_w[k-1].dvd[QUO_W-2:0], 1'b0};
            if (trial >= {1'b0, r_w[k-1].item.mag_b}) begin
                n_w[k].rem = trial - {1'b0, r_w[k-1].item.mag_b};
                n_w[k].quo = {r_w[k-1].quo[QUO_W-2:0], 1'b1};
            end else begin
                n_w[k].rem = trial;
                n_w[k].quo = {r_w[k-1].quo[QUO_W-2:0], 1'b0};
            end
        end
    end

    always_comb begin
        last      = r_w[QUO_W];
        n_out.res = last.item.res;
        n_out.cmp = last.item.cmp;
        n_out.dbz = last.item.dbz;
        n_out.ovf = last.item.ovf;
        q         = '0;
        case (last.item.kind)
            KIND_MUL: q = (last.prod + HALF) >> FRAC_BITS;
            KIND_DIV: q = PROD_W'(last.quo)
                          + PROD_W'({last.rem[DATA_W-1:0], 1'b0} >= {1'b0, last.item.mag_b});
            default: q = '0;
        endcase
        if (last.item.kind != KIND_DONE) begin
            if (last.item.neg) begin
                if (q > NEG_LIM) begin
                    n_out.res = NEG_LIM[DATA_W-1:0];
                    n_out.ovf = 1'b1;
                end else begin
                    n_out.res = ~q[DATA_W-1:0] + 1'b1;
                end
            end else begin
                if (q > POS_LIM) begin
                    n_out.res = POS_LIM[DATA_W-1:0];
                    n_out.ovf = 1'b1;
                end else begin
                    n_out.res = q[DATA_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_w[0].item <= i_item;
            r_w[0].prod <= PROD_W'(i_item.mag_a) * PROD_W'(i_item.mag_b);
            r_w[0].rem  <= '0;
            r_w[0].quo  <= '0;
            r_w[0].dvd  <= {i_item.mag_a, FRAC_BITS'(0)};
            for (int k = 1; k <= QUO_W; k++) begin
                r_w[k] <= n_w[k];
            end
            r_out <= n_out;
        end
        if (!i_rst_n) begin
            for (int k = 0; k <= QUO_W; k++) begin
                r_v[k] <= 1'b0;
            end
            r_out_v <= 1'b0;
        end else if (en) begin
            r_v[0] <= i_valid;
            for (int k = 1; k <= QUO_W; k++) begin
                r_v[k] <= r_v[k-1];
            end
            r_out_v <= r_v[QUO_W];
        end
    end

endmodule

@@ rtl/core/q24_8_fixed_point_alu.sv @@
// Q24.8 fixed-point ALU. Each transfer on the slave side carries an opcode in tuser and
// two signed raw operands in tdata, and yields exactly one result transfer in order.
// Multiply and divide round to nearest with halves away from zero, arithmetic results saturate,
// and a zero divisor returns zero with its flag set. The block takes one item per cycle
// and returns one per cycle while tready is high; every item goes through the queue and the
// forty-stage restoring divider pipeline, so that order holds.
module q24_8_fixed_point_alu (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [63:0] i_s_axis_tdata,  // operand_a, operand_b
    input  logic [3:0]  i_s_axis_tuser,  // opcode
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,  // result_raw
    output logic [2:0]  o_m_axis_tuser   // compare_true, divide_by_zero, overflow
);
    import fa_pkg::*;

    t_item   front_item;
    t_item   q_item;
    logic    q_full;
    logic    q_valid;
    logic    pop;
    t_result res;

    fa_front u_front (
        .i_op   (t_op'(i_s_axis_tuser)),
        .i_a    (i_s_axis_tdata[31:0]),
        .i_b    (i_s_axis_tdata[63:32]),
        .o_item (front_item)
    );

    fa_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_s_axis_tvalid),
        .i_item  (front_item),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    fa_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_valid),
        .i_item   (q_item),
        .o_pop    (pop),
        .o_valid  (o_m_axis_tvalid),
        .o_result (res),
        .i_ready  (i_m_axis_tready)
    );

    assign o_s_axis_tready = !q_full;
    assign o_m_axis_tdata  = res.res;
    assign o_m_axis_tuser  = {res.ovf, res.dbz, res.cmp};

endmodule

@@ sim/alu_checker.sv @@
module alu_checker
    import fa_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_valid,
    input  logic        i_s_ready,
    input  logic [63:0] i_s_data,
    input  logic [3:0]  i_s_user,
    input  logic        i_m_valid,
    input  logic        i_m_ready,
    input  logic [31:0] i_m_data,
    input  logic [2:0]  i_m_user,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_results_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    t_result expected_results[$];

    function automatic logic signed [31:0] saturate(input logic signed [63:0] v,
                                                    inout logic ovf);
        if (v > 64'sd2147483647) begin
            ovf = 1'b1;
            return 32'sh7fffffff;
        end
        if (v < -64'sd2147483648) begin
            ovf = 1'b1;
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    function automatic t_result alu_predict(input t_op op, input logic signed [31:0] a32,
                                            input logic signed [31:0] b32);
        t_result r;
        logic signed [63:0] a, b, p;
        logic [63:0] m, q, na, db;
        logic ovf;
        a = a32;
        b = b32;
        ovf = 1'b0;
        r = '0;
        case (op)
            OP_ADD: r.res = saturate(a + b, ovf);
            OP_SUB: r.res = saturate(a - b, ovf);
            OP_MUL: begin
                p = a * b;
                m = p < 0 ? -p : p;
                q = (m + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
                r.res = saturate(p < 0 ? -$signed(q) : $signed(q), ovf);
            end
            OP_DIV: begin
                if (b == 0) begin
                    r.dbz = 1'b1;
                end else begin
                    na = (a < 0 ? -a : a) << FRAC_BITS;
                    db = b < 0 ? -b : b;
                    q = (2 * na + db) / (2 * db);
                    r.res = saturate(((a < 0) != (b < 0)) ? -$signed(q) : $signed(q), ovf);
                end
            end
            OP_GT: r.cmp = a > b;
            OP_GE: r.cmp = a >= b;
            OP_LT: r.cmp = a < b;
            OP_LE: r.cmp = a <= b;
            OP_EQ: r.cmp = a == b;
            OP_NE: r.cmp = a != b;
            OP_MIN: r.res = a > b ? b32 : a32;
            OP_MAX: r.res = a > b ? a32 : b32;
            OP_INC: r.res = saturate(a + 1, ovf);
            OP_DEC: r.res = saturate(a - 1, ovf);
            OP_FROM_INT: r.res = saturate(a <<< FRAC_BITS, ovf);
            default: r.res = a32 >>> FRAC_BITS;
        endcase
        r.ovf = ovf;
        return r;
    endfunction

    assign o_pending = expected_results.size();

    always @(posedge i_clk) begin
        t_result want;
        int      errs;
        errs = 0;
        if (!i_rst_n) begin
            o_fail_count <= 0;
            o_results_seen <= 0;
        end else begin
            if (i_s_valid && i_s_ready)
                expected_results.push_back(alu_predict(t_op'(i_s_user),
                                                       i_s_data[31:0], i_s_data[63:32]));
            if (i_m_valid && i_m_ready) begin
                o_results_seen <= o_results_seen + 1;
                if (expected_results.size() == 0) begin
                    $error("result transfer with no expectation: data %h", i_m_data);
                    errs++;
                end else begin
                    want = expected_results.pop_front();
                    if (want.res !== i_m_data) begin
                        $error("result_raw: expected %h, actual %h", want.res, i_m_data);
                        errs++;
                    end
                    if (want.cmp !== i_m_user[0]) begin
                        $error("compare_true: expected %b, actual %b", want.cmp, i_m_user[0]);
                        errs++;
                    end
                    if (want.dbz !== i_m_user[1]) begin
                        $error("divide_by_zero: expected %b, actual %b",
                               want.dbz, i_m_user[1]);
                        errs++;
                    end
                    if (want.ovf !== i_m_user[2]) begin
                        $error("overflow: expected %b, actual %b", want.ovf, i_m_user[2]);
                        errs++;
                    end
                end
            end
            o_fail_count <= o_fail_count + errs;
        end
    end
endmodule

@@ sim/tb.sv @@
module tb;
    import fa_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 5000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [63:0] s_data = '0;
    logic [3:0]  s_user = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_data;
    logic [2:0]  m_user;
    int          fail_count, pending, results_seen;
    int          idle_cycles = 0;
    int          hold_off = 0;
    bit          long_hold_done = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    q24_8_fixed_point_alu u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_axis_tvalid(s_valid), .o_s_axis_tready(s_ready),
        .i_s_axis_tdata(s_data), .i_s_axis_tuser(s_user),
        .o_m_axis_tvalid(m_valid), .i_m_axis_tready(m_ready),
        .o_m_axis_tdata(m_data), .o_m_axis_tuser(m_user)
    );

    alu_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_valid(s_valid), .i_s_ready(s_ready), .i_s_data(s_data), .i_s_user(s_user),
        .i_m_valid(m_valid), .i_m_ready(m_ready), .i_m_data(m_data), .i_m_user(m_user),
        .o_fail_count(fail_count), .o_pending(pending), .o_results_seen(results_seen)
    );

    // The receiver stalls in its own pattern, with one long hold-off early in the run.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_ready <= 1'b0;
        end else if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_ready <= 1'b0;
        end else if (!long_hold_done && results_seen > 40) begin
            long_hold_done <= 1'b1;
            hold_off <= 200;
            m_ready <= 1'b0;
        end else if ($urandom_range(0, 15) == 0) begin
            hold_off <= $urandom_range(1, 12);
            m_ready <= 1'b0;
        end else begin
            m_ready <= (results_seen / 64) % 3 == 0 ? 1'b1 : ($urandom_range(0, 3) != 0);
        end
    end

    always @(posedge i_clk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 7))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return '0;
            3: return $urandom_range(0, 2048) - 1024;
            4: return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom())};
            default: return $urandom();
        endcase
    endfunction

    task automatic send(input t_op op, input logic [31:0] a, input logic [31:0] b);
        s_valid <= 1'b1;
        s_user <= op;
        s_data <= {b, a};
        @(posedge i_clk);
        while (!s_ready) @(posedge i_clk);
    endtask

    task automatic pause_sender(input int cycles);
        s_valid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    initial begin
        int burst;
        int n;
        t_op op;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send(OP_ADD, 32'h7fffffff, 32'h00000001);
        send(OP_SUB, 32'h80000000, 32'h00000001);
        send(OP_MUL, 32'h7fffffff, 32'h7fffffff);
        send(OP_MUL, 32'h00000180, 32'hffffff80);
        send(OP_MUL, 32'h80000000, 32'h80000000);
        send(OP_DIV, 32'h00000100, 32'h00000000);
        send(OP_DIV, 32'h80000000, 32'hffffffff);
        send(OP_DIV, 32'hffffff00, 32'h00000300);
        send(OP_DIV, 32'h7fffffff, 32'h80000000);
        send(OP_GT, 32'h80000000, 32'h7fffffff);
        send(OP_GE, 32'h00000005, 32'h00000005);
        send(OP_LT, 32'h80000000, 32'h7fffffff);
        send(OP_LE, 32'h7fffffff, 32'h7fffffff);
        send(OP_EQ, 32'hffffffff, 32'hffffffff);
        send(OP_NE, 32'h00000000, 32'h80000000);
        send(OP_MIN, 32'h00000007, 32'h00000007);
        send(OP_MAX, 32'h80000000, 32'h7fffffff);
        send(OP_INC, 32'h7fffffff, 32'h12345678);
        send(OP_DEC, 32'h80000000, 32'hffffffff);
        send(OP_FROM_INT, 32'h00800000, 32'h0);
        send(OP_FROM_INT, 32'hff7fffff, 32'h0);
        send(OP_TO_INT, 32'hffffff01, 32'h0);
        send(OP_TO_INT, 32'h7fffffff, 32'h0);
        s_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);

        n = 0;
        while (n < 800) begin
            burst = $urandom_range(1, 40);
            for (int i = 0; i < burst && n < 800; i++) begin
                op = t_op'($urandom_range(0, 15));
                send(op, pick_operand(), ($urandom_range(0, 9) == 0) ? '0 : pick_operand());
                n++;
            end
            if ($urandom_range(0, 2) != 0)
                pause_sender($urandom_range(1, 10));
            if (n >= 400 && n < 400 + burst) begin
                s_valid <= 1'b0;
                while (pending != 0) @(posedge i_clk);
            end
        end
        s_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);

        $display("Ran the directed edge cases and 800 random operations over all opcodes,");
        $display("with sender gaps, receiver stalls and one long output hold-off.");
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule

@@ q24_8_fixed_point_alu.f @@
rtl/core/fa_pkg.sv
rtl/core/fa_front.sv
rtl/core/fa_queue.sv
rtl/core/fa_back.sv
rtl/core/q24_8_fixed_point_alu.sv
sim/alu_checker.sv
sim/tb.sv
